@@ hw/rtl/vmct_pkg.sv @@
// Shared types, register indexes and constants of the video mode capability table.
// Used by vmct_cell, video_mode_capability_table_core and the bench; depends on nothing.
package vmct_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int DIM_W  = 11;
	localparam int IV_W   = 6;
	localparam int FT_W   = 20;
	localparam int MPI_W  = 9;
	localparam int DIST_W = 2 * DIM_W;
	localparam int PER_W  = 18;
	localparam int RECIP_W = 21;
	localparam int DPROD_W = FT_W + RECIP_W;
	localparam int REM_W  = 21;

	localparam logic [IV_W-1:0]    DISABLED_CODE = 6'd33;
	localparam logic [PER_W-1:0]   TICKS = 18'd3003;
	localparam logic [RECIP_W-1:0] RECIP = 21'd1430224;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_NEG   = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOTFND  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_DES_W = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DES_H = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_W = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MIN_H = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_W = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MAX_H = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FT    = 3'd6;

	localparam logic [DIM_W-1:0] RST_DES_W = 11'd176;
	localparam logic [DIM_W-1:0] RST_DES_H = 11'd144;
	localparam logic [DIM_W-1:0] RST_MIN_W = 11'd176;
	localparam logic [DIM_W-1:0] RST_MIN_H = 11'd144;
	localparam logic [DIM_W-1:0] RST_MAX_W = 11'd704;
	localparam logic [DIM_W-1:0] RST_MAX_H = 11'd576;
	localparam logic [FT_W-1:0]  RST_FT    = 20'd3003;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [IV_W-1:0]  iv;
	} entry_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic              lim_ok;
		logic              found;
		logic [DIST_W-1:0] best_d;
		logic [DIM_W-1:0]  sel_w;
		logic [DIM_W-1:0]  sel_h;
		logic [IV_W-1:0]   sel_iv;
	} probe_t;

endpackage

@@ hw/rtl/vmct_cell.sv @@
// One table cell: holds a single entry and updates the passing probe.
// Depends on vmct_pkg.
module vmct_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       active,
	input  logic                       wr_en,
	input  vmct_pkg::entry_t           wr_entry,
	input  logic [vmct_pkg::DIM_W-1:0] desired_width,
	input  logic [vmct_pkg::DIM_W-1:0] desired_height,
	input  logic                       in_valid,
	input  vmct_pkg::probe_t           in_probe,
	output logic                       out_valid,
	output vmct_pkg::probe_t           out_probe
);

	vmct_pkg::entry_t                  ent_q;
	vmct_pkg::probe_t                  probe_q;
	logic                              valid_q;
	vmct_pkg::probe_t                  nxt;
	logic [vmct_pkg::DIM_W-1:0]        dw;
	logic [vmct_pkg::DIM_W-1:0]        dh;
	logic [vmct_pkg::DIST_W-1:0]       prod_d;

	always_comb begin
		dw = (ent_q.w > desired_width) ? ent_q.w - desired_width : desired_width - ent_q.w;
		dh = (ent_q.h > desired_height) ? ent_q.h - desired_height : desired_height - ent_q.h;
		prod_d = vmct_pkg::DIST_W'(dw) * vmct_pkg::DIST_W'(dh);
		nxt = in_probe;
		if (in_probe.op == vmct_pkg::OP_QUERY && active && in_probe.lim_ok &&
				!in_probe.found && ent_q.w == in_probe.w && ent_q.h == in_probe.h) begin
			nxt.found  = 1'b1;
			nxt.sel_iv = ent_q.iv;
		end
		if (in_probe.op == vmct_pkg::OP_NEG && active &&
				(!in_probe.found || prod_d < in_probe.best_d)) begin
			nxt.found  = 1'b1;
			nxt.best_d = prod_d;
			nxt.sel_w  = ent_q.w;
			nxt.sel_h  = ent_q.h;
			nxt.sel_iv = ent_q.iv;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q <= wr_entry;
		end
		if (in_valid) begin
			probe_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	assign out_valid = valid_q;
	assign out_probe = probe_q;

endmodule

@@ hw/rtl/video_mode_capability_table_core.sv @@
// An add result passes the finish register and then the output register before it raises
// m_tvalid; a query, a negotiate or an unused op first walks the cell chain one cell a cycle
// and then passes both registers. One item at a time: the next transfer is taken once the
// result has moved into the output register, so no new item is taken while one is in flight.
// Reset clears the entry count, the config registers to their defaults and all valids;
// entry contents are not cleared.
module video_mode_capability_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,  // op, width, height, interval, zero pad
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [55:0]                 m_tdata,  // status, mpi_value, chosen_width,
	                                              // chosen_height, neg_frame_time, zero pad
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vmct_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int DEPTH = vmct_pkg::DEPTH;
	localparam int DIM_W = vmct_pkg::DIM_W;
	localparam int IV_W  = vmct_pkg::IV_W;
	localparam int FT_W  = vmct_pkg::FT_W;
	localparam int MPI_W = vmct_pkg::MPI_W;
	localparam int CNT_W = vmct_pkg::CNT_W;
	localparam int IDX_W = vmct_pkg::IDX_W;
	localparam int PER_W = vmct_pkg::PER_W;
	localparam int REM_W = vmct_pkg::REM_W;
	localparam int DPROD_W = vmct_pkg::DPROD_W;

	logic [DIM_W-1:0] des_w_q, des_h_q, min_w_q, min_h_q, max_w_q, max_h_q;
	logic [FT_W-1:0]  ft_q;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             fin_valid_q;
	logic [1:0]       fin_status_q;
	logic [MPI_W-1:0] fin_mpi_q;
	logic [DIM_W-1:0] fin_cw_q, fin_ch_q;
	logic [FT_W-1:0]  fin_nft_q;
	logic             m_valid_q;
	logic [55:0]      m_data_q;
	logic [DPROD_W-1:0] div_prod_q;
	logic [MPI_W-1:0]   div_quot_q;

	logic [1:0]       in_op;
	logic [DIM_W-1:0] in_w, in_h;
	logic [IV_W-1:0]  in_iv;
	logic             in_xfer;
	logic             cfg_wr;
	logic [vmct_pkg::REG_IDX_W-1:0] cfg_idx;
	logic             add_ok;
	logic             full;
	logic [1:0]       add_status;
	vmct_pkg::probe_t inj_probe;
	vmct_pkg::entry_t wr_entry;
	logic             chain_v [DEPTH+1];
	vmct_pkg::probe_t chain_p [DEPTH+1];
	logic [DEPTH-1:0] cell_active;
	logic [DEPTH-1:0] cell_wr;
	vmct_pkg::probe_t end_p;
	logic             end_v;
	logic [MPI_W-1:0] q0;
	logic [REM_W-1:0] rem;
	logic [PER_W-1:0] end_per;
	logic [1:0]       res_status;
	logic [MPI_W-1:0] res_mpi;
	logic [DIM_W-1:0] res_cw, res_ch;
	logic [FT_W-1:0]  res_nft;
	logic             out_free;

	assign in_op   = s_tdata[1:0];
	assign in_w    = s_tdata[12:2];
	assign in_h    = s_tdata[23:13];
	assign in_iv   = s_tdata[29:24];
	assign s_tready = !busy_q && !fin_valid_q;
	assign in_xfer = s_tvalid && s_tready;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			vmct_pkg::REG_DES_W: prdata = 32'(des_w_q);
			vmct_pkg::REG_DES_H: prdata = 32'(des_h_q);
			vmct_pkg::REG_MIN_W: prdata = 32'(min_w_q);
			vmct_pkg::REG_MIN_H: prdata = 32'(min_h_q);
			vmct_pkg::REG_MAX_W: prdata = 32'(max_w_q);
			vmct_pkg::REG_MAX_H: prdata = 32'(max_h_q);
			vmct_pkg::REG_FT:    prdata = 32'(ft_q);
			default:             prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			des_w_q <= vmct_pkg::RST_DES_W;
			des_h_q <= vmct_pkg::RST_DES_H;
			min_w_q <= vmct_pkg::RST_MIN_W;
			min_h_q <= vmct_pkg::RST_MIN_H;
			max_w_q <= vmct_pkg::RST_MAX_W;
			max_h_q <= vmct_pkg::RST_MAX_H;
			ft_q    <= vmct_pkg::RST_FT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				vmct_pkg::REG_DES_W: des_w_q <= pwdata[DIM_W-1:0];
				vmct_pkg::REG_DES_H: des_h_q <= pwdata[DIM_W-1:0];
				vmct_pkg::REG_MIN_W: min_w_q <= pwdata[DIM_W-1:0];
				vmct_pkg::REG_MIN_H: min_h_q <= pwdata[DIM_W-1:0];
				vmct_pkg::REG_MAX_W: max_w_q <= pwdata[DIM_W-1:0];
				vmct_pkg::REG_MAX_H: max_h_q <= pwdata[DIM_W-1:0];
				vmct_pkg::REG_FT:    ft_q    <= pwdata[FT_W-1:0];
				default: ;
			endcase
		end
	end

	// frame_time / 3003: reciprocal multiply, then one correction step
	assign q0  = div_prod_q[DPROD_W-1:32];
	assign rem = REM_W'(ft_q) - REM_W'(q0) * REM_W'(vmct_pkg::TICKS);

	always_ff @(posedge clk) begin
		div_prod_q <= DPROD_W'(ft_q) * DPROD_W'(vmct_pkg::RECIP);
		div_quot_q <= (rem >= REM_W'(vmct_pkg::TICKS)) ? q0 + MPI_W'(1) : q0;
	end

	assign full   = count_q >= CNT_W'(DEPTH);
	assign add_ok = in_xfer && in_op == vmct_pkg::OP_ADD && in_iv != vmct_pkg::DISABLED_CODE
		&& !full;
	assign add_status = (in_iv == vmct_pkg::DISABLED_CODE) ? vmct_pkg::ST_IGNORED :
		(full ? vmct_pkg::ST_FULL : vmct_pkg::ST_OK);

	assign wr_entry.w  = in_w;
	assign wr_entry.h  = in_h;
	assign wr_entry.iv = in_iv;

	always_comb begin
		inj_probe        = '0;
		inj_probe.op     = in_op;
		inj_probe.w      = in_w;
		inj_probe.h      = in_h;
		inj_probe.lim_ok = in_w <= max_w_q && in_h <= max_h_q &&
			in_w >= min_w_q && in_h >= min_h_q;
	end

	assign chain_v[0] = in_xfer && in_op != vmct_pkg::OP_ADD;
	assign chain_p[0] = inj_probe;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_active[i] = CNT_W'(i) < count_q;
		assign cell_wr[i]     = add_ok && count_q[IDX_W-1:0] == IDX_W'(i);

		vmct_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.active         (cell_active[i]),
			.wr_en          (cell_wr[i]),
			.wr_entry       (wr_entry),
			.desired_width  (des_w_q),
			.desired_height (des_h_q),
			.in_valid       (chain_v[i]),
			.in_probe       (chain_p[i]),
			.out_valid      (chain_v[i+1]),
			.out_probe      (chain_p[i+1])
		);
	end

	assign end_v = chain_v[DEPTH];
	assign end_p = chain_p[DEPTH];
	assign end_per = PER_W'(end_p.sel_iv) * vmct_pkg::TICKS;

	always_comb begin
		res_status = vmct_pkg::ST_NOTFND;
		res_mpi    = '0;
		res_cw     = '0;
		res_ch     = '0;
		res_nft    = '0;
		case (end_p.op)
			vmct_pkg::OP_QUERY: begin
				if (end_p.found) begin
					res_status = vmct_pkg::ST_OK;
					res_mpi = (FT_W'(end_per) > ft_q) ? MPI_W'(end_p.sel_iv) : div_quot_q;
				end else begin
					res_mpi = MPI_W'(vmct_pkg::DISABLED_CODE);
				end
			end
			vmct_pkg::OP_NEG: begin
				if (end_p.found) begin
					res_status = vmct_pkg::ST_OK;
					res_cw  = end_p.sel_w;
					res_ch  = end_p.sel_h;
					res_nft = (FT_W'(end_per) > ft_q) ? FT_W'(end_per) : ft_q;
				end
			end
			default: ;
		endcase
	end

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			fin_valid_q <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (add_ok) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (chain_v[0]) begin
				busy_q <= 1'b1;
			end else if (end_v) begin
				busy_q <= 1'b0;
			end
			if ((in_xfer && in_op == vmct_pkg::OP_ADD) || end_v) begin
				fin_valid_q <= 1'b1;
			end else if (fin_valid_q && out_free) begin
				fin_valid_q <= 1'b0;
			end
			if (fin_valid_q && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && in_op == vmct_pkg::OP_ADD) begin
			fin_status_q <= add_status;
			fin_mpi_q    <= '0;
			fin_cw_q     <= '0;
			fin_ch_q     <= '0;
			fin_nft_q    <= '0;
		end else if (end_v) begin
			fin_status_q <= res_status;
			fin_mpi_q    <= res_mpi;
			fin_cw_q     <= res_cw;
			fin_ch_q     <= res_ch;
			fin_nft_q    <= res_nft;
		end
		if (fin_valid_q && out_free) begin
			m_data_q <= {3'b000, fin_nft_q, fin_ch_q, fin_cw_q, fin_mpi_q, fin_status_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && fin_valid_q))
		else $error("chain busy while a finished result is pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("transfer taken while previous item in flight");

	a_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		end_v |=> (fin_valid_q && !busy_q))
		else $error("chain result not captured");

endmodule

@@ sim/tb.sv @@
// Self-checking bench for video_mode_capability_table_core: directed and random add, query and
// negotiate traffic over several register settings, checked against a behavioral table model.
// Depends on vmct_pkg and the core RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vmct_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 240;

	typedef struct packed {
		logic [1:0]       pad;
		logic [IV_W-1:0]  iv;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] w;
		logic [1:0]       op;
	} mode_req_t;

	typedef struct packed {
		logic [2:0]       pad;
		logic [FT_W-1:0]  nft;
		logic [DIM_W-1:0] ch;
		logic [DIM_W-1:0] cw;
		logic [MPI_W-1:0] mpi;
		logic [1:0]       status;
	} mode_rsp_t;

	class mode_table_tracker;
		logic [DIM_W-1:0] des_w, des_h, min_w, min_h, max_w, max_h;
		logic [FT_W-1:0]  ft;
		logic [DIM_W-1:0] tab_w[DEPTH];
		logic [DIM_W-1:0] tab_h[DEPTH];
		logic [IV_W-1:0]  tab_iv[DEPTH];
		int unsigned      count;
		mode_rsp_t        replies_due[$];
		int unsigned      mismatches;
		int unsigned      n_stored, n_hits, n_negs;

		function new();
			des_w = RST_DES_W;
			des_h = RST_DES_H;
			min_w = RST_MIN_W;
			min_h = RST_MIN_H;
			max_w = RST_MAX_W;
			max_h = RST_MAX_H;
			ft = RST_FT;
			count = 0;
			mismatches = 0;
			n_stored = 0;
			n_hits = 0;
			n_negs = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
			case (idx)
				REG_DES_W: des_w = v[DIM_W-1:0];
				REG_DES_H: des_h = v[DIM_W-1:0];
				REG_MIN_W: min_w = v[DIM_W-1:0];
				REG_MIN_H: min_h = v[DIM_W-1:0];
				REG_MAX_W: max_w = v[DIM_W-1:0];
				REG_MAX_H: max_h = v[DIM_W-1:0];
				REG_FT:    ft = v[FT_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned span(logic [DIM_W-1:0] a, logic [DIM_W-1:0] b);
			return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
		endfunction

		function void note_request(mode_req_t r);
			mode_rsp_t   e;
			int unsigned d, best, bi, t, ftu, tick, ivu;
			bit          hit;
			e = '0;
			e.status = ST_NOTFND;
			ftu = ft;
			tick = TICKS;
			hit = 0;
			case (r.op)
				OP_ADD: begin
					if (r.iv == DISABLED_CODE) begin
						e.status = ST_IGNORED;
					end else if (count >= DEPTH) begin
						e.status = ST_FULL;
					end else begin
						tab_w[count] = r.w;
						tab_h[count] = r.h;
						tab_iv[count] = r.iv;
						count++;
						n_stored++;
						e.status = ST_OK;
					end
				end
				OP_QUERY: begin
					e.mpi = MPI_W'(DISABLED_CODE);
					if (count != 0 && r.w <= max_w && r.h <= max_h &&
					    r.w >= min_w && r.h >= min_h) begin
						for (int i = 0; i < count && !hit; i++) begin
							if (tab_w[i] == r.w && tab_h[i] == r.h) begin
								hit = 1;
								ivu = tab_iv[i];
								e.status = ST_OK;
								e.mpi = (ivu * tick > ftu) ? MPI_W'(ivu) : MPI_W'(ftu / tick);
							end
						end
					end
					if (hit)
						n_hits++;
				end
				OP_NEG: begin
					n_negs++;
					if (count != 0) begin
						best = 32'hFFFF_FFFF;
						bi = 0;
						for (int i = 0; i < count; i++) begin
							d = span(tab_w[i], des_w) * span(tab_h[i], des_h);
							if (d < best) begin
								best = d;
								bi = i;
							end
						end
						t = int'(tab_iv[bi]) * tick;
						e.status = ST_OK;
						e.cw = tab_w[bi];
						e.ch = tab_h[bi];
						e.nft = (t > ftu) ? FT_W'(t) : FT_W'(ftu);
					end
				end
				default: ;
			endcase
			replies_due = {replies_due, e};
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_reply(mode_rsp_t got);
			mode_rsp_t e;
			if (replies_due.size() == 0) begin
				report($sformatf("result with nothing pending: status %0d", got.status));
				return;
			end
			e = replies_due.pop_front();
			if (got.status !== e.status || got.mpi !== e.mpi || got.cw !== e.cw ||
			    got.ch !== e.ch || got.nft !== e.nft)
				report({$sformatf("got st %0d mpi %0d %0dx%0d ft %0d",
					got.status, got.mpi, got.cw, got.ch, got.nft),
					$sformatf(", want st %0d mpi %0d %0dx%0d ft %0d",
					e.status, e.mpi, e.cw, e.ch, e.nft)});
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [31:0]         s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [55:0]         m_tdata;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	mode_table_tracker tracker;
	bit                idle_on = 1'b1;
	int unsigned       cycles = 0;
	int unsigned       n_sent = 0;
	int unsigned       n_settings = 1;

	video_mode_capability_table_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= idle_on ? ($urandom_range(0, 99) >= 11) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_reply(mode_rsp_t'(m_tdata));
	end

	task automatic send_request(mode_req_t r);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= r;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_request(r);
		n_sent++;
	endtask

	// hold off new transfers until every pending result is back
	task automatic drain_replies();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		tracker.write_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic [DIM_W-1:0] dw, logic [DIM_W-1:0] dh,
	                          logic [DIM_W-1:0] lw, logic [DIM_W-1:0] lh,
	                          logic [DIM_W-1:0] hw, logic [DIM_W-1:0] hh,
	                          logic [FT_W-1:0] ft);
		write_reg(REG_DES_W, 32'(dw));
		write_reg(REG_DES_H, 32'(dh));
		write_reg(REG_MIN_W, 32'(lw));
		write_reg(REG_MIN_H, 32'(lh));
		write_reg(REG_MAX_W, 32'(hw));
		write_reg(REG_MAX_H, 32'(hh));
		write_reg(REG_FT, 32'(ft));
		n_settings++;
	endtask

	function automatic mode_req_t make_req(logic [1:0] op, logic [DIM_W-1:0] w,
	                                       logic [DIM_W-1:0] h, logic [IV_W-1:0] iv);
		mode_req_t r;
		r = '0;
		r.op = op;
		r.w = w;
		r.h = h;
		r.iv = iv;
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] pick_in(logic [DIM_W-1:0] lo, logic [DIM_W-1:0] hi);
		if (lo <= hi)
			return DIM_W'($urandom_range(int'(lo), int'(hi)));
		return DIM_W'($urandom);
	endfunction

	function automatic logic [DIM_W-1:0] near_limit(logic [DIM_W-1:0] lo, logic [DIM_W-1:0] hi);
		case ($urandom_range(0, 3))
			0: return lo - 1'b1;
			1: return lo;
			2: return hi;
			default: return hi + 1'b1;
		endcase
	endfunction

	function automatic logic [FT_W-1:0] random_frame_time();
		case ($urandom_range(0, 3))
			0: return FT_W'($urandom_range(0, 200000));
			1: return FT_W'(int'(TICKS) * $urandom_range(0, 63));
			2: return FT_W'($urandom);
			default: return FT_W'($urandom_range(0, 12012));
		endcase
	endfunction

	function automatic mode_req_t random_request();
		mode_req_t   r;
		int unsigned k, sel, idx;
		r = make_req(OP_UNUSED, DIM_W'($urandom), DIM_W'($urandom), IV_W'($urandom));
		k = $urandom_range(0, 99);
		sel = $urandom_range(0, 99);
		idx = (tracker.count != 0) ? $urandom_range(0, tracker.count - 1) : 0;
		if (k < ((tracker.count < DEPTH) ? 12 : 20)) begin
			r.op = OP_ADD;
			if ($urandom_range(0, 7) == 0)
				r.iv = DISABLED_CODE;
			if (sel < 40) begin
				r.w = pick_in(tracker.min_w, tracker.max_w);
				r.h = pick_in(tracker.min_h, tracker.max_h);
			end else if (sel < 70 && tracker.count != 0) begin
				r.w = tracker.tab_w[idx];
				r.h = tracker.tab_h[idx];
			end
		end else if (k < 60) begin
			r.op = OP_QUERY;
			if (sel < 65 && tracker.count != 0) begin
				r.w = tracker.tab_w[idx];
				r.h = tracker.tab_h[idx];
			end else if (sel < 82) begin
				r.w = near_limit(tracker.min_w, tracker.max_w);
				r.h = $urandom_range(0, 1) ? near_limit(tracker.min_h, tracker.max_h)
				                           : pick_in(tracker.min_h, tracker.max_h);
			end
		end else if (k < 94) begin
			r.op = OP_NEG;
		end
		return r;
	endfunction

	task automatic phase_setup(int unsigned p);
		logic [DIM_W-1:0] dw, dh, lw, lh, hw, hh;
		int unsigned      idx;
		case (p)
			0: ;
			1: set_config(0, 0, 0, 0, 2047, 2047, 0);
			2: set_config(2047, 2047, 2047, 2047, 2047, 2047, 20'hFFFFF);
			3: set_config(0, 2047, 0, 0, 0, 0, 20'(TICKS));
			4: set_config(352, 288, 704, 576, 176, 144, random_frame_time());
			default: begin
				idx = $urandom_range(0, tracker.count - 1);
				dw = $urandom_range(0, 1) ? tracker.tab_w[idx] : DIM_W'($urandom);
				dh = $urandom_range(0, 1) ? tracker.tab_h[idx] : DIM_W'($urandom);
				lw = DIM_W'($urandom_range(0, 400));
				lh = DIM_W'($urandom_range(0, 400));
				hw = DIM_W'($urandom_range(500, 2047));
				hh = DIM_W'($urandom_range(500, 2047));
				set_config(dw, dh, lw, lh, hw, hh, random_frame_time());
			end
		endcase
	endtask

	task automatic directed_requests();
		send_request(make_req(OP_NEG, 0, 0, 0));
		send_request(make_req(OP_QUERY, 176, 144, 0));
		send_request(make_req(OP_UNUSED, 0, 0, 0));
		send_request(make_req(OP_ADD, 352, 288, DISABLED_CODE));
		send_request(make_req(OP_ADD, 0, 0, 0));
		send_request(make_req(OP_ADD, 2047, 2047, 63));
		send_request(make_req(OP_ADD, 176, 144, 1));
		send_request(make_req(OP_ADD, 704, 576, 2));
		send_request(make_req(OP_ADD, 352, 288, 0));
		send_request(make_req(OP_ADD, 352, 288, 5));
		send_request(make_req(OP_QUERY, 176, 144, 0));
		send_request(make_req(OP_QUERY, 704, 576, 0));
		send_request(make_req(OP_QUERY, 352, 288, 63));
		send_request(make_req(OP_QUERY, 0, 0, 0));
		send_request(make_req(OP_QUERY, 2047, 2047, 0));
		send_request(make_req(OP_QUERY, 175, 144, 0));
		send_request(make_req(OP_QUERY, 704, 577, 0));
		send_request(make_req(OP_QUERY, 400, 300, 0));
		send_request(make_req(OP_NEG, 2047, 2047, 63));
		send_request(make_req(OP_UNUSED, 2047, 2047, 63));
		send_request(make_req(OP_ADD, 2047, 0, 62));
		send_request(make_req(OP_ADD, 0, 2047, 32));
		send_request(make_req(OP_ADD, 1024, 1023, 34));
		send_request(make_req(OP_NEG, 0, 0, 0));
	endtask

	initial begin
		tracker = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_requests();
		for (int unsigned p = 0; p < PHASES; p++) begin
			drain_replies();
			phase_setup(p);
			idle_on = (p != 5);
			for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 6 && i == PHASE_ITEMS / 2)
					drain_replies();
				send_request(random_request());
			end
		end
		drain_replies();
		repeat (DEPTH + 8) @(posedge clk);
		$display("Ran %0d requests over %0d register settings; %0d entries stored.",
			n_sent, n_settings, tracker.n_stored);
		$display("Queries matched: %0d, negotiations: %0d, mismatches: %0d.",
			tracker.n_hits, tracker.n_negs, tracker.mismatches);
		if (tracker.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ video_mode_capability_table_core.f @@
hw/rtl/vmct_pkg.sv
hw/rtl/vmct_cell.sv
hw/rtl/video_mode_capability_table_core.sv
sim/tb.sv
